>>> hw/rtl/deq_pkg.sv
// deq_pkg: shared types, codes and sizes of the double-ended queue
`default_nettype none

package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // operation codes carried in the kind field
    localparam logic [2:0] KIND_INS_FRONT  = 3'd0;
    localparam logic [2:0] KIND_INS_REAR   = 3'd1;
    localparam logic [2:0] KIND_DEL_FRONT  = 3'd2;
    localparam logic [2:0] KIND_DEL_REAR   = 3'd3;
    localparam logic [2:0] KIND_PEEK_FRONT = 3'd4;
    localparam logic [2:0] KIND_PEEK_REAR  = 3'd5;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0] kind;
        data_t      value;
    } req_t;

    typedef struct packed {
        status_t status;
        data_t   peek_value;
    } rsp_t;

    // per-cell movement, broadcast along the chain
    typedef struct packed {
        logic shift_r;
        logic shift_l;
    } cell_cmd_t;

    // decoded operation from the controller
    typedef struct packed {
        logic             shift_r;
        logic             shift_l;
        logic             load_rear;
        logic [CNT_W-1:0] count;
    } deq_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/deq_cell.sv
// deq_cell: one storage cell of the queue chain
`default_nettype none

module deq_cell (
    input  wire logic              clk,
    input  wire deq_pkg::cell_cmd_t cmd,
    input  wire logic              load,
    input  wire deq_pkg::data_t    ins_value,
    input  wire deq_pkg::data_t    left_data,
    input  wire deq_pkg::data_t    right_data,
    output deq_pkg::data_t         data
);
    import deq_pkg::*;

    data_t data_reg;
    data_t data_next;

    // pick the next content: own load, neighbor on the left or on the right, else hold
    always_comb
    begin
        data_next = data_reg;
        if (load)
        begin
            data_next = ins_value;
        end
        else if (cmd.shift_r)
        begin
            data_next = left_data;
        end
        else if (cmd.shift_l)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/deq_ctrl.sv
// deq_ctrl: operation decode, status and entry count of the queue
`default_nettype none

module deq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire logic [2:0]     kind,
    output deq_pkg::deq_ctrl_t  ctrl,
    output deq_pkg::status_t    status
);
    import deq_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             full;
    logic             empty;
    logic             is_ins;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign is_ins = (kind == KIND_INS_FRONT) || (kind == KIND_INS_REAR);

    // decode the operation against the current fill level
    always_comb
    begin
        ctrl       = '0;
        ctrl.count = count_reg;
        status     = ST_OK;
        count_next = count_reg;
        case (kind)
            KIND_INS_FRONT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctrl.shift_r = fire;
                    if (fire)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            KIND_INS_REAR:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctrl.load_rear = fire;
                    if (fire)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            KIND_DEL_FRONT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    ctrl.shift_l = fire;
                    if (fire)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            KIND_DEL_REAR:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (fire)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_PEEK_FRONT, KIND_PEEK_REAR:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.shift_r && ctrl.shift_l) && !(ctrl.load_rear && ctrl.shift_r))
        else $error("conflicting chain moves");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_ins && full) |=> $stable(count_reg))
        else $error("refused insert changed the count");

    a_move_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |-> (ctrl.shift_r == 1'b0 && ctrl.shift_l == 1'b0 && ctrl.load_rear == 1'b0))
        else $error("chain moved without a transfer");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/double_ended_queue_top.sv
// double_ended_queue_top: chain-of-cells double-ended queue with registered result
//
// Usage: a request (kind, value) is a transfer on req_valid/req_ready; every
// request gives exactly one response (status, peek_value) on rsp_valid/rsp_ready.
// Elements live in a row of DEPTH cells with the front always in cell 0.
// Insert front shifts the whole row one place toward the rear,
// delete front shifts it one place toward the front, insert rear loads the
// cell at the entry count, delete rear only lowers the count.
// Response: registered at the request transfer, valid in the cycle after it.
// Throughput: one request per cycle while rsp_ready is high or no response waits;
// the rear peek is a DEPTH-way select on the entry count, which sets the cycle time.
// Stall: while a response waits and rsp_ready is low, req_ready is low; when
// rsp_ready is high a new request is taken in the same cycle the response leaves.
// Reset: rst_n clears the entry count and the response valid flag; the cell
// contents are not cleared and only cells holding live entries are ever read.
`default_nettype none

module double_ended_queue_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire deq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output deq_pkg::rsp_t      rsp
);
    import deq_pkg::*;

    logic      fire;
    deq_ctrl_t ctrl;
    status_t   status;
    cell_cmd_t cmd;
    data_t     cell_data [DEPTH];
    logic [CNT_W-1:0] rear_cnt;
    logic [IDX_W-1:0] rear_idx;
    data_t     peek;

    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    // request transfer
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign fire      = req_valid && req_ready;

    deq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .kind   (req.kind),
        .ctrl   (ctrl),
        .status (status)
    );

    assign cmd.shift_r = ctrl.shift_r;
    assign cmd.shift_l = ctrl.shift_l;

    // row of cells, front at index 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        data_t left_d;
        data_t right_d;
        logic  load_i;

        if (i == 0)
        begin : g_first
            assign left_d = req.value;
        end
        else
        begin : g_mid
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_inner
            assign right_d = cell_data[i+1];
        end

        assign load_i = ctrl.load_rear && (ctrl.count[IDX_W-1:0] == IDX_W'(i));

        deq_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .load       (load_i),
            .ins_value  (req.value),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i])
        );
    end

    // end select for peeks
    assign rear_cnt = ctrl.count - 1'b1;
    assign rear_idx = rear_cnt[IDX_W-1:0];

    always_comb
    begin
        peek = '0;
        if (status == ST_OK)
        begin
            if (req.kind == KIND_PEEK_FRONT)
            begin
                peek = cell_data[0];
            end
            else if (req.kind == KIND_PEEK_REAR)
            begin
                peek = cell_data[rear_idx];
            end
        end
    end

    // response register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (fire)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.status     = status;
            rsp_next.peek_value = peek;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid_reg)
        else $error("transfer without response");

    a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready) |-> !req_ready)
        else $error("request taken over a stalled response");

    a_peek_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && status != ST_OK) |=> (rsp_reg.peek_value == '0))
        else $error("nonzero value with error status");
`endif

endmodule

`default_nettype wire

>>> verif/tb_double_ended_queue_top.sv
// tb_double_ended_queue_top: self-checking testbench for the double-ended queue, with a ring-buffer shadow model
`default_nettype none

module tb_double_ended_queue_top;
    import deq_pkg::*;

    localparam int IDLE_LIMIT  = 1000;
    localparam int RANDOM_OPS  = 520;
    localparam int REPORT_MAX  = 10;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_ready;
    req_t  req       = '0;
    logic  rsp_valid;
    logic  rsp_ready = 1'b0;
    rsp_t  rsp;

    // requests waiting to be driven and responses still owed by the block
    req_t  pending_ops[$];
    rsp_t  owed_replies[$];

    // shadow deque: ring store, front slot and occupancy
    data_t       ring [DEPTH];
    int unsigned head      = 0;
    int unsigned fill      = 0;
    int unsigned plan_fill = 0;

    int unsigned ops_sent     = 0;
    int unsigned replies_seen = 0;
    int unsigned full_refused = 0;
    int unsigned empty_hits   = 0;
    int unsigned peak_fill    = 0;
    int unsigned fail_count   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned req_gap      = 0;
    int unsigned req_calm     = 0;
    int unsigned rsp_stall    = 0;
    int unsigned rsp_calm     = 0;

    double_ended_queue_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // clock, period 12
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int unsigned draw_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // apply one operation to the shadow deque and queue its reply
    function automatic void apply_deque_op(input req_t op);
        rsp_t reply;
        reply.status     = ST_OK;
        reply.peek_value = '0;
        case (op.kind)
            KIND_INS_FRONT:
                if (fill == DEPTH)
                    reply.status = ST_FULL;
                else
                begin
                    head = (head + DEPTH - 1) % DEPTH;
                    ring[head] = op.value;
                    fill++;
                end
            KIND_INS_REAR:
                if (fill == DEPTH)
                    reply.status = ST_FULL;
                else
                begin
                    ring[(head + fill) % DEPTH] = op.value;
                    fill++;
                end
            KIND_DEL_FRONT:
                if (fill == 0)
                    reply.status = ST_EMPTY;
                else
                begin
                    head = (head + 1) % DEPTH;
                    fill--;
                end
            KIND_DEL_REAR:
                if (fill == 0)
                    reply.status = ST_EMPTY;
                else
                    fill--;
            KIND_PEEK_FRONT:
                if (fill == 0)
                    reply.status = ST_EMPTY;
                else
                    reply.peek_value = ring[head];
            KIND_PEEK_REAR:
                if (fill == 0)
                    reply.status = ST_EMPTY;
                else
                    reply.peek_value = ring[(head + fill - 1) % DEPTH];
            default:
                ;
        endcase
        if (reply.status == ST_FULL)
            full_refused++;
        if (reply.status == ST_EMPTY)
            empty_hits++;
        if (fill > peak_fill)
            peak_fill = fill;
        owed_replies.push_back(reply);
    endfunction

    // queue a request and track the occupancy it will leave behind
    task automatic add_op(input logic [2:0] kind, input data_t value);
        req_t op;
        op.kind  = kind;
        op.value = value;
        pending_ops.push_back(op);
        if ((kind == KIND_INS_FRONT || kind == KIND_INS_REAR) && plan_fill < DEPTH)
            plan_fill++;
        else if ((kind == KIND_DEL_FRONT || kind == KIND_DEL_REAR) && plan_fill > 0)
            plan_fill--;
    endtask

    function automatic data_t pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return -32'sd1;
            default: return data_t'($urandom);
        endcase
    endfunction

    // one random request; grow_pct sets how often it inserts
    task automatic add_random_op(input int unsigned grow_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < grow_pct)
            add_op($urandom_range(0, 1) ? KIND_INS_REAR : KIND_INS_FRONT, pick_value());
        else if (r < 97)
        begin
            if ($urandom_range(0, 2) != 0)
                add_op($urandom_range(0, 1) ? KIND_DEL_REAR : KIND_DEL_FRONT, pick_value());
            else
                add_op($urandom_range(0, 1) ? KIND_PEEK_REAR : KIND_PEEK_FRONT, pick_value());
        end
        else
            add_op(3'($urandom_range(6, 7)), pick_value());
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                apply_deque_op(req);
                ops_sent++;
            end
            if (!req_valid || req_ready)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_valid <= 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    req       <= pending_ops.pop_front();
                    req_valid <= 1'b1;
                    req_gap   = draw_gap(req_calm);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // response monitor and ready throttling
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                replies_seen++;
                if (owed_replies.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("response with none outstanding: status %0d value %0d",
                                 rsp.status, rsp.peek_value);
                end
                else if (owed_replies[0].status !== rsp.status ||
                         owed_replies[0].peek_value !== rsp.peek_value)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("response %0d: expected status %0d value %0d, got status %0d value %0d",
                                 replies_seen, owed_replies[0].status,
                                 owed_replies[0].peek_value, rsp.status, rsp.peek_value);
                    void'(owed_replies.pop_front());
                end
                else
                    void'(owed_replies.pop_front());
                rsp_stall = draw_gap(rsp_calm);
            end
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int unsigned random_ops;
        int unsigned style;
        int unsigned start_len;

        // directed: empty deque, unused codes, extremes at both ends
        add_op(KIND_PEEK_FRONT, '0);
        add_op(KIND_PEEK_REAR, '0);
        add_op(KIND_DEL_FRONT, '0);
        add_op(KIND_DEL_REAR, '0);
        add_op(3'd6, -32'sd1);
        add_op(3'd7, '0);
        add_op(KIND_INS_FRONT, 32'sh7fffffff);
        add_op(KIND_INS_REAR, 32'sh80000000);
        add_op(KIND_PEEK_FRONT, -32'sd1);
        add_op(KIND_PEEK_REAR, -32'sd1);
        add_op(KIND_INS_FRONT, '0);
        add_op(KIND_INS_REAR, -32'sd1);
        add_op(KIND_PEEK_FRONT, '0);
        add_op(KIND_PEEK_REAR, '0);
        add_op(KIND_DEL_FRONT, -32'sd1);
        add_op(KIND_DEL_REAR, -32'sd1);
        add_op(KIND_PEEK_FRONT, '0);
        add_op(KIND_PEEK_REAR, '0);
        add_op(KIND_DEL_REAR, '0);
        add_op(KIND_PEEK_REAR, '0);
        add_op(KIND_DEL_FRONT, '0);
        add_op(KIND_PEEK_FRONT, '0);

        // random episodes: fill to full, drain to empty, or mixed traffic
        random_ops = 0;
        while (random_ops < RANDOM_OPS)
        begin
            style     = $urandom_range(0, 2);
            start_len = pending_ops.size();
            if (style == 0)
            begin
                while (plan_fill < DEPTH)
                    add_random_op(80);
                repeat ($urandom_range(1, 5))
                    add_random_op(80);
            end
            else if (style == 1)
            begin
                while (plan_fill > 0)
                    add_random_op(15);
                repeat ($urandom_range(1, 5))
                    add_random_op(15);
            end
            else
                repeat ($urandom_range(10, 40))
                    add_random_op(35);
            random_ops += pending_ops.size() - start_len;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // poll every cycle until all requests are out and all responses checked
        while (pending_ops.size() != 0 || req_valid || owed_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("ran %0d requests, checked %0d responses, %0d mismatches",
                 ops_sent, replies_seen, fail_count);
        $display("full refusals %0d, empty replies %0d, peak occupancy %0d of %0d",
                 full_refused, empty_hits, peak_fill, DEPTH);
        if (fail_count == 0 && owed_replies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
